FILE: rtl/core/mexp_pkg.sv
// Shared constants and types for the modular exponentiation block.
`default_nettype none

package mexp_pkg;

  localparam int unsigned OPERAND_BITS_DEF = 16;
  localparam int unsigned MODULUS_RESET    = 143;

  // Which modular product the shared unit is forming.
  typedef enum logic [1:0] {
    OP_REDUCE = 2'd0,
    OP_MULT   = 2'd1,
    OP_SQUARE = 2'd2
  } op_e;

endpackage

`default_nettype wire

FILE: rtl/core/modular_exponentiation.sv
// Top level: right-to-left square and multiply modular exponentiation.
`default_nettype none

// Computes base_value_i ** exponent_i mod modulus, one result per request. The modulus
// is written through the cfg channel (reset value 143) and must only be changed while
// the block is idle; a modulus of zero gives 0. All products run on a single
// interleaved shift-add modular multiplier that consumes one multiplier bit per cycle.
// A request costs one product to reduce the base, one per set exponent bit and one
// squaring per bit below the top set bit: at most 2*OPERAND_BITS products, and none
// for a zero modulus. in_stall_o stays high for the whole computation; the result
// register lets the next request in while a finished result still waits on
// out_stall_i.
module modular_exponentiation #(
  parameter int unsigned OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [OPERAND_BITS-1:0] cfg_modulus_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [OPERAND_BITS-1:0] base_value_i,
  input  logic [OPERAND_BITS-1:0] exponent_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [OPERAND_BITS-1:0] power_result_o
);
  import mexp_pkg::*;

  localparam int unsigned W    = OPERAND_BITS;
  localparam int unsigned CntW = $clog2(OPERAND_BITS);
  localparam logic [CntW-1:0] CntLast = CntW'(OPERAND_BITS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_NEXT = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]      state_q, state_d;
  op_e             op_q, op_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    mod_q;
  logic [W-1:0]    x_q, x_d, y_q, y_d, r_q, r_d;
  logic [W-1:0]    acc_q, acc_d, base_q, base_d, exp_q, exp_d;
  logic            out_valid_q, out_valid_d;
  logic [W-1:0]    result_q, result_d;

  logic [W-1:0]    init_val;
  logic [W+1:0]    sum, once_m, twice_m, red;
  logic [W-1:0]    r_next;
  logic            out_free;

  // The user must write configuration only while idle; the block does not enforce it, so take it at once.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= W'(MODULUS_RESET);
    end else if (cfg_valid_i) begin
      mod_q <= cfg_modulus_i;
    end
  end

  // 1 mod m: zero for a modulus of one.
  assign init_val = (mod_q == W'(1)) ? '0 : W'(1);

  // One step of the interleaved multiplier: r = 2r + x*bit, then bring back below m.
  always_comb begin
    sum     = {1'b0, r_q, 1'b0} + {2'b00, (y_q[W-1] ? x_q : {W{1'b0}})};
    once_m  = {2'b00, mod_q};
    twice_m = {1'b0, mod_q, 1'b0};
    if (sum >= twice_m) begin
      red = sum - twice_m;
    end else if (sum >= once_m) begin
      red = sum - once_m;
    end else begin
      red = sum;
    end
    r_next = red[W-1:0];
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    cnt_d    = cnt_q;
    x_d      = x_q;
    y_d      = y_q;
    r_d      = r_q;
    acc_d    = acc_q;
    base_d   = base_q;
    exp_d    = exp_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          exp_d = exponent_i;
          if (mod_q == '0) begin
            acc_d   = '0;
            state_d = ST_FIN;
          end else begin
            // Reduce the base as the product (1 mod m) * base.
            acc_d   = init_val;
            x_d     = init_val;
            y_d     = base_value_i;
            r_d     = '0;
            cnt_d   = '0;
            op_d    = OP_REDUCE;
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        r_d   = r_next;
        y_d   = y_q << 1;
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntLast) begin
          state_d = ST_NEXT;
          case (op_q)
            OP_REDUCE: base_d = r_next;
            OP_MULT: begin
              acc_d    = r_next;
              exp_d[0] = 1'b0;
            end
            OP_SQUARE: begin
              base_d = r_next;
              exp_d  = exp_q >> 1;
            end
            default: ;
          endcase
        end
      end
      ST_NEXT: begin
        r_d   = '0;
        cnt_d = '0;
        if (exp_q[0]) begin
          x_d     = acc_q;
          y_d     = base_q;
          op_d    = OP_MULT;
          state_d = ST_MUL;
        end else if (exp_q == '0) begin
          // No set bits left: further squarings cannot change the result.
          state_d = ST_FIN;
        end else begin
          x_d     = base_q;
          y_d     = base_q;
          op_d    = OP_SQUARE;
          state_d = ST_MUL;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    result_d    = result_q;
    if (state_q == ST_FIN && out_free) begin
      out_valid_d = 1'b1;
      result_d    = acc_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_REDUCE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    y_q      <= y_d;
    r_q      <= r_d;
    acc_q    <= acc_d;
    base_q   <= base_d;
    exp_q    <= exp_d;
    result_q <= result_d;
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign power_result_o = result_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted but block did not go busy");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_FIN)
    else $error("result raised outside the finish state");

  a_product_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL && cnt_q == CntLast |=> state_q == ST_NEXT)
    else $error("modular product did not end after its last bit");
`endif

endmodule

`default_nettype wire

FILE: tb/mexp_checker.sv
// Checker for the modular exponentiation block: predicts each power and compares results.
`timescale 1ns / 1ps

module mexp_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic                                  cfg_ready_i,
  input  logic [mexp_pkg::OPERAND_BITS_DEF-1:0] cfg_modulus_i,
  input  logic                                  in_valid_i,
  input  logic                                  in_stall_i,
  input  logic [mexp_pkg::OPERAND_BITS_DEF-1:0] base_value_i,
  input  logic [mexp_pkg::OPERAND_BITS_DEF-1:0] exponent_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_stall_i,
  input  logic [mexp_pkg::OPERAND_BITS_DEF-1:0] power_result_i,
  output int unsigned                           pending_o,
  output int unsigned                           fail_count_o
);
  import mexp_pkg::*;

  localparam int unsigned W = OPERAND_BITS_DEF;

  typedef logic [W-1:0] word_t;

  word_t modulus_q;
  word_t expected_powers[$];

  // Right-to-left square and multiply; products held at double width.
  function automatic word_t mod_power(word_t base, word_t expo, word_t modulus);
    logic [2*W-1:0] acc;
    logic [2*W-1:0] square;
    if (modulus == '0) return '0;
    acc    = (2*W)'(1 % modulus);
    square = (2*W)'(base % modulus);
    for (int i = 0; i < W; i++) begin
      if (expo[i]) acc = (acc * square) % modulus;
      square = (square * square) % modulus;
    end
    return acc[W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count_o = fail_count_o + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    word_t want;
    if (!rst_ni) begin
      modulus_q <= word_t'(MODULUS_RESET);
      expected_powers.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i === 1'b1 && cfg_ready_i === 1'b1) modulus_q <= cfg_modulus_i;
      // Retire before queueing so a result is never matched with its own request.
      if (out_valid_i === 1'b1 && out_stall_i == 1'b0) begin
        if (expected_powers.size() == 0) begin
          report_mismatch($sformatf("result %0d with no request outstanding", power_result_i));
        end else begin
          want = expected_powers.pop_front();
          if (power_result_i !== want)
            report_mismatch($sformatf("power_result %0d, predicted %0d", power_result_i, want));
        end
      end
      if (in_valid_i == 1'b1 && in_stall_i === 1'b0)
        expected_powers.push_back(mod_power(base_value_i, exponent_i, modulus_q));
      pending_o <= expected_powers.size();
    end
  end

endmodule

FILE: tb/tb_modular_exponentiation.sv
// Testbench top for the modular exponentiation block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_modular_exponentiation;
  import mexp_pkg::*;

  localparam int unsigned W = OPERAND_BITS_DEF;
  localparam int unsigned PHASES = 10;
  localparam int unsigned PHASE_REQUESTS = 125;
  localparam int unsigned DRAIN_CYCLES = 600;

  typedef struct packed {
    logic [W-1:0] modulus;
    logic [W-1:0] base;
    logic [W-1:0] expo;
  } probe_t;

  // Directed requests, grouped by modulus; the first group runs at the reset value.
  localparam probe_t PROBES[19] = '{
    '{16'd143, 16'h0000, 16'h0000},
    '{16'd143, 16'h0000, 16'h0005},
    '{16'd143, 16'hFFFF, 16'hFFFF},
    '{16'd143, 16'h0001, 16'hFFFF},
    '{16'd143, 16'd142,  16'h0002},
    '{16'd143, 16'd143,  16'h0007},
    '{16'd143, 16'd144,  16'h0003},
    '{16'd143, 16'd12,   16'h8000},
    '{16'd143, 16'hFFFF, 16'h0001},
    '{16'd143, 16'h0002, 16'hFFFF},
    '{16'd143, 16'h0007, 16'h5555},
    '{16'd143, 16'hAAAA, 16'hAAAA},
    '{16'd1,   16'h0005, 16'h0000},
    '{16'd1,   16'hFFFF, 16'hFFFF},
    '{16'd0,   16'h0003, 16'h0004},
    '{16'd0,   16'h0000, 16'h0000},
    '{16'hFFFF, 16'hFFFE, 16'hFFFF},
    '{16'hFFFF, 16'hFFFF, 16'h0003},
    '{16'hFFFF, 16'h0002, 16'h0010}
  };

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [W-1:0] cfg_modulus_i;
  logic         in_valid_i;
  logic         in_stall_o;
  logic [W-1:0] base_value_i;
  logic [W-1:0] exponent_i;
  logic         out_valid_o;
  logic         out_stall_i = 1'b0;
  logic [W-1:0] power_result_o;

  logic        idle_en = 1'b1;
  int unsigned stall_left = 0;
  int unsigned pending;
  int unsigned fail_count;

  modular_exponentiation #(
    .OPERAND_BITS(W)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_modulus_i (cfg_modulus_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .base_value_i  (base_value_i),
    .exponent_i    (exponent_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .power_result_o(power_result_o)
  );

  mexp_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_modulus_i (cfg_modulus_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .base_value_i  (base_value_i),
    .exponent_i    (exponent_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .power_result_i(power_result_o),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the result side in short random bursts; new bursts start only while idle_en is set.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_en && $urandom_range(99) < 2) begin
      stall_left  <= $urandom_range(0, 5);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_request(input logic [W-1:0] base, input logic [W-1:0] expo);
    if (idle_en && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    base_value_i <= base;
    exponent_i   <= expo;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  // Drop valid and hold until every outstanding request has produced its result.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_modulus(input logic [W-1:0] modulus);
    cfg_valid_i   <= 1'b1;
    cfg_modulus_i <= modulus;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [W-1:0] modulus;
    logic [W-1:0] base;
    logic [W-1:0] expo;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_modulus_i = '0;
    in_valid_i    = 1'b0;
    base_value_i  = '0;
    exponent_i    = '0;
    modulus       = W'(MODULUS_RESET);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (PROBES[i]) begin
      if (PROBES[i].modulus != modulus) begin
        wait_drained();
        modulus = PROBES[i].modulus;
        write_modulus(modulus);
      end
      send_request(PROBES[i].base, PROBES[i].expo);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase)
        0:       modulus = 16'd65521;
        1:       modulus = 16'd3;
        2:       modulus = W'($urandom_range(1, 65535));
        3:       modulus = W'($urandom_range(2, 300));
        4:       modulus = 16'h8000;
        5:       modulus = 16'hFFFF;
        6:       modulus = 16'd1;
        7:       modulus = W'($urandom_range(1, 65535));
        8:       modulus = 16'd0;
        default: modulus = 16'd257;
      endcase
      write_modulus(modulus);
      // One phase runs back to back with no gaps on either side.
      idle_en = (phase != 3);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        case ($urandom_range(0, 7))
          0:       base = W'($urandom_range(0, 3));
          1:       base = modulus - W'($urandom_range(0, 1));
          2:       base = 16'hFFFF - W'($urandom_range(0, 3));
          default: base = W'($urandom);
        endcase
        case ($urandom_range(0, 7))
          0:       expo = W'($urandom_range(0, 3));
          1:       expo = W'(1) << $urandom_range(0, W - 1);
          2, 3:    expo = W'($urandom_range(0, 255));
          default: expo = W'($urandom);
        endcase
        send_request(base, expo);
        if (phase == 5 && n == PHASE_REQUESTS / 2) wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
